>>> rtl/sha256_stream_hasher_defines.svh
// Assertion macros for the SHA-256 stream hasher.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define SHS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sha256 hasher check failed");
// Checked on every rising edge, reset included.
`define SHS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("sha256 hasher check failed");
`else
`define SHS_ASSERT(name, prop)
`define SHS_ASSERT_ALWAYS(name, prop)
`endif

`endif

>>> rtl/sha256_pkg.sv
// Types and constants of the SHA-256 stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FOLD  = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  localparam logic [7:0] PAD_MARK    = 8'h80;
  localparam logic [5:0] BLK_LAST    = 6'd63;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] ROUND_LAST  = 6'd63;
  localparam logic [2:0] WORD_LAST   = 3'd7;
  localparam logic [63:0] BYTE_BITS  = 64'd8;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

`default_nettype wire

>>> rtl/sha256_stream_hasher.sv
// SHA-256 over a byte stream: block buffer, round unit and digest output.
//
// Takes one message byte per input request (tuser flags the byte as present,
// tlast ends the message) and returns the 256-bit digest as eight 32-bit
// requests, most significant word first. Bytes are taken one per cycle into a
// 512-bit block shift line; when the 64th byte of a block arrives, tready drops
// while a single round unit runs the 64 rounds (one per cycle, schedule words
// produced in the same shift line) and a fold step adds the result into the
// hash state; no bytes are taken until that block is done. On end of message
// the padding and the 64-bit bit length are shifted in one byte per cycle up
// to the block end, using an extra block when the length does not fit, each
// block again followed by the rounds and the fold; the eight digest words then
// leave one per cycle as the sink takes them, and the hash returns to its
// initial value for the next message. No input is taken while a digest is
// pending. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_stream_hasher_defines.svh"

module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] byte_present
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]       m_axis_tuser,   // [2:0] word_number
  output logic             m_axis_tlast    // last_word
);

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  state_e       state_q, state_d;
  logic [5:0]   fill_q, fill_d;
  logic [63:0]  bits_q, bits_d;
  logic         pad_q, pad_d;      // finalizing the current message
  logic         mark_q, mark_d;    // 0x80 already pushed
  logic         lenok_q, lenok_d;  // length may go into bytes 56..63
  logic         done_q, done_d;    // block under compression is the last
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   cnt_q, cnt_d;
  logic [31:0]  hash_q [8];
  logic [31:0]  hash_d [8];
  logic [31:0]  v_q [8];
  logic [31:0]  v_d [8];
  logic [511:0] blk_q, blk_d;

  logic         push;
  logic [7:0]   push_byte;
  logic [7:0]   len_byte;
  logic [31:0]  w0, w1, w9, w14, wn;
  logic [31:0]  s0, s1, big0, big1, choose, major, t1;

  // Word k of the window sits at [511-32k -: 32]; word 0 feeds the round.
  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];

  assign s0 = ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3);
  assign s1 = ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10);
  assign wn = w0 + s0 + w9 + s1;

  assign big1   = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
  assign choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1     = v_q[7] + big1 + choose + ROUND_K[rnd_q] + w0;
  assign big0   = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
  assign major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);

  // Big-endian length: byte 56 carries bits 63..56.
  assign len_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    bits_d    = bits_q;
    pad_d     = pad_q;
    mark_d    = mark_q;
    lenok_d   = lenok_q;
    done_d    = done_q;
    rnd_d     = rnd_q;
    cnt_d     = cnt_q;
    hash_d    = hash_q;
    v_d       = v_q;
    blk_d     = blk_q;
    push      = 1'b0;
    push_byte = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          pad_d = s_axis_tlast;
          if (s_axis_tuser) begin
            push      = 1'b1;
            push_byte = s_axis_tdata;
            bits_d    = bits_q + BYTE_BITS;
          end
          if (s_axis_tuser && fill_q == BLK_LAST) begin
            state_d = ST_ROUND;
          end else if (s_axis_tlast) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        if (!mark_q) begin
          push_byte = PAD_MARK;
          mark_d    = 1'b1;
          lenok_d   = (fill_q < LEN_POS) || (fill_q == BLK_LAST);
        end else begin
          push_byte = (lenok_q && fill_q >= LEN_POS) ? len_byte : 8'h00;
          if (fill_q == BLK_LAST) begin
            if (lenok_q) begin
              done_d = 1'b1;
            end else begin
              lenok_d = 1'b1;
            end
          end
        end
        if (fill_q == BLK_LAST) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        v_d[0] = t1 + big0 + major;
        v_d[1] = v_q[0];
        v_d[2] = v_q[1];
        v_d[3] = v_q[2];
        v_d[4] = v_q[3] + t1;
        v_d[5] = v_q[4];
        v_d[6] = v_q[5];
        v_d[7] = v_q[6];
        blk_d  = {blk_q[479:0], wn};
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == ROUND_LAST) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v_q[i];
        end
        if (done_q) begin
          state_d = ST_OUT;
          cnt_d   = '0;
        end else if (pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (m_axis_tready) begin
          // Shift the digest out; the initial values refill behind it.
          for (int i = 0; i < 7; i++) begin
            hash_d[i] = hash_q[i + 1];
          end
          hash_d[7] = INIT_H[cnt_q];
          cnt_d     = cnt_q + 3'd1;
          if (cnt_q == WORD_LAST) begin
            state_d = ST_IDLE;
            bits_d  = '0;
            pad_d   = 1'b0;
            mark_d  = 1'b0;
            lenok_d = 1'b0;
            done_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (push) begin
      blk_d  = {blk_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
      if (fill_q == BLK_LAST) begin
        v_d   = hash_q;
        rnd_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      pad_q   <= 1'b0;
      mark_q  <= 1'b0;
      lenok_q <= 1'b0;
      done_q  <= 1'b0;
      rnd_q   <= '0;
      cnt_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= INIT_H[i];
      end
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      pad_q   <= pad_d;
      mark_q  <= mark_d;
      lenok_q <= lenok_d;
      done_q  <= done_d;
      rnd_q   <= rnd_d;
      cnt_q   <= cnt_d;
      hash_q  <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    blk_q <= blk_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = hash_q[0];
  assign m_axis_tuser  = cnt_q;
  assign m_axis_tlast  = (cnt_q == WORD_LAST);

  `SHS_ASSERT_ALWAYS(a_no_overlap, !(s_axis_tready && m_axis_tvalid))
  `SHS_ASSERT(a_round_start, (state_q == ST_ROUND && $past(state_q) != ST_ROUND) |-> rnd_q == 6'd0)
  `SHS_ASSERT(a_out_block_empty, m_axis_tvalid |-> fill_q == 6'd0)
  `SHS_ASSERT(a_last_fold_out, (state_q == ST_FOLD && done_q) |=> m_axis_tvalid)

endmodule

`default_nettype wire
